/* rtl/brnd_pkg.sv */
package brnd_pkg;

  // Default pixel count of one packed word
  localparam int unsigned WordBitsDefault = 32;

  // Result queue depth; a power of two so the pointers wrap on their own
  localparam int unsigned OutFifoDepth = 4;

  // Results produced by one accepted request
  typedef struct packed {
    logic held_done;  // held word finished by this request's first pixel
    logic row_done;   // request closes the row and its own word is finished
  } brnd_push_t;

endpackage

/* rtl/brnd_word_filter.sv */
module brnd_word_filter import brnd_pkg::*; #(
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  logic [WORD_BITS-1:0] up_i,
  input  logic [WORD_BITS-1:0] mid_i,
  input  logic [WORD_BITS-1:0] down_i,
  input  logic                 left_px_i,
  input  logic                 right_px_i,
  output logic [WORD_BITS-1:0] word_o
);

  logic [WORD_BITS-1:0] left_nb;
  logic [WORD_BITS-1:0] right_nb;
  logic [WORD_BITS-1:0] three_set;

  // Align each pixel with its left and right neighbor
  assign left_nb  = {mid_i[WORD_BITS-2:0], left_px_i};
  assign right_nb = {right_px_i, mid_i[WORD_BITS-1:1]};

  // Keep a set pixel when at least three of four neighbors are set
  assign three_set = (up_i & down_i & left_nb) | (up_i & down_i & right_nb) |
                     (up_i & left_nb & right_nb) | (down_i & left_nb & right_nb);
  assign word_o    = mid_i & three_set;

endmodule

/* rtl/brnd_row_ctrl.sv */
module brnd_row_ctrl import brnd_pkg::*; #(
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [WORD_BITS-1:0] top_word_i,
  input  logic [WORD_BITS-1:0] cur_word_i,
  input  logic [WORD_BITS-1:0] bot_word_i,
  input  logic                 last_in_row_i,
  output brnd_push_t           push_o,
  output logic [WORD_BITS-1:0] held_word_o,
  output logic [WORD_BITS-1:0] row_word_o
);

  logic [WORD_BITS-1:0] held_top_q, held_cur_q, held_bot_q;
  logic                 left_px_q, left_px_d;
  logic                 pending_q, pending_d;
  logic                 row_left_px;

  // Left pixel of the incoming word: last pixel of the held word, or zero
  assign row_left_px = pending_q & held_cur_q[WORD_BITS-1];

  // Finish the held word now that its right neighbor has arrived
  brnd_word_filter #(.WORD_BITS(WORD_BITS)) u_held_filter (
    .up_i       (held_top_q),
    .mid_i      (held_cur_q),
    .down_i     (held_bot_q),
    .left_px_i  (left_px_q),
    .right_px_i (cur_word_i[0]),
    .word_o     (held_word_o)
  );

  // Finish the incoming word when it closes the row
  brnd_word_filter #(.WORD_BITS(WORD_BITS)) u_row_filter (
    .up_i       (top_word_i),
    .mid_i      (cur_word_i),
    .down_i     (bot_word_i),
    .left_px_i  (row_left_px),
    .right_px_i (1'b0),
    .word_o     (row_word_o)
  );

  assign push_o.held_done = fire_i & pending_q;
  assign push_o.row_done  = fire_i & last_in_row_i;

  // Drop held state at a row end, otherwise hold the incoming word
  always_comb begin
    left_px_d = left_px_q;
    pending_d = pending_q;
    if (fire_i) begin
      left_px_d = ~last_in_row_i & row_left_px;
      pending_d = ~last_in_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_px_q <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      left_px_q <= left_px_d;
      pending_q <= pending_d;
    end
  end

  // Capture the incoming words
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      held_top_q <= top_word_i;
      held_cur_q <= cur_word_i;
      held_bot_q <= bot_word_i;
    end
  end

endmodule

/* rtl/brnd_out_fifo.sv */
module brnd_out_fifo import brnd_pkg::*; #(
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  brnd_push_t           push_i,
  input  logic [WORD_BITS-1:0] held_word_i,
  input  logic [WORD_BITS-1:0] row_word_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WORD_BITS-1:0] out_word_o,
  output logic                 row_end_o
);

  localparam int unsigned PtrW = $clog2(OutFifoDepth);
  localparam int unsigned CntW = $clog2(OutFifoDepth + 1);
  localparam logic [CntW-1:0] StallLevel = CntW'(OutFifoDepth - 1);

  logic [WORD_BITS:0]   mem_q [OutFifoDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [WORD_BITS:0]   slot0, slot1;
  logic [1:0]           n_push;
  logic                 pop;

  // Pack results in order: the held word first, the row-closing word second
  assign slot0  = push_i.held_done ? {1'b0, held_word_i} : {1'b1, row_word_i};
  assign slot1  = {1'b1, row_word_i};
  assign n_push = {1'b0, push_i.held_done} + {1'b0, push_i.row_done};

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o & ~out_stall_i;
  assign {row_end_o, out_word_o} = mem_q[rd_ptr_q];

  // Stall the input while fewer than two slots are free
  assign full_o = (count_q >= StallLevel);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(n_push);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write up to two results
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= slot0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= slot1;
    end
  end

endmodule

/* rtl/binary_row_neighbour_denoise_top.sv */
// Binary row denoiser: four-neighbour majority filter over packed pixel words.
// Input channel (in_valid_i / in_stall_o): one request carries a word of the
// row above, the current row and the row below, plus last_in_row_i marking
// the final word of the row. Bit k is pixel k from the left.
// Output channel (out_valid_o / out_stall_i): filtered words of the current
// row; row_end_o marks the last word of a row.
// A word is finished once the next word supplies its right neighbor, so
// results lag one request; the request that closes a row yields two results
// (one for a single-word row). A result enters the result queue as the
// request that completes it is accepted, behind any earlier results.
// Throughput: one request per cycle while in_stall_o is low; a row of N
// words yields N results, the row-closing request's extra result being
// absorbed by a four-entry result queue.
// in_stall_o rises when fewer than two queue slots are free, so a stalled
// receiver backs up into the input after a few requests; nothing is dropped.
// Reset clears the queue and the held-word state; no result is pending.
module binary_row_neighbour_denoise_top import brnd_pkg::*; #(
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WORD_BITS-1:0] top_word_i,
  input  logic [WORD_BITS-1:0] cur_word_i,
  input  logic [WORD_BITS-1:0] bot_word_i,
  input  logic                 last_in_row_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WORD_BITS-1:0] out_word_o,
  output logic                 row_end_o
);

  brnd_push_t           push;
  logic [WORD_BITS-1:0] held_word;
  logic [WORD_BITS-1:0] row_word;
  logic                 fifo_full;
  logic                 in_fire;

  assign in_stall_o = fifo_full;
  assign in_fire    = in_valid_i & ~fifo_full;

  brnd_row_ctrl #(.WORD_BITS(WORD_BITS)) u_row_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .top_word_i    (top_word_i),
    .cur_word_i    (cur_word_i),
    .bot_word_i    (bot_word_i),
    .last_in_row_i (last_in_row_i),
    .push_o        (push),
    .held_word_o   (held_word),
    .row_word_o    (row_word)
  );

  brnd_out_fifo #(.WORD_BITS(WORD_BITS)) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .held_word_i (held_word),
    .row_word_i  (row_word),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .row_end_o   (row_end_o)
  );

endmodule
